FILE: rtl/thd_pkg.sv
`default_nettype none

package thd_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned CNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_FIND       = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL  = 3'd2,
    ST_MISS  = 3'd3,
    ST_NULL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/task_handle_deque.sv
// Channel   Handshake                      Payload
// request   in_valid_i / in_stall_o        op_i, handle_in_i, key_in_i
// result    out_valid_o / out_stall_i      handle_out_o, status_o, count_out_o
//
// A push, an unused op code, or a pop or find on an empty queue goes from S_IDLE to S_DONE,
// a pop passes through S_READ and a find through S_SCAN; from S_DONE the result enters the
// output register once it is free. The find scan reads one memory entry a cycle.
// One request is in work at a time; the next is taken the cycle after the result enters the
// output register, even while that result still waits on out_stall_i.
// Reset empties the queue at once; memory contents are not cleared.
`default_nettype none

module task_handle_deque #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [thd_pkg::OP_W-1:0]    op_i,
  input  wire logic [thd_pkg::DATA_W-1:0]  handle_in_i,
  input  wire logic [thd_pkg::KEY_W-1:0]   key_in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [thd_pkg::DATA_W-1:0]       handle_out_o,
  output logic [thd_pkg::ST_W-1:0]         status_o,
  output logic [thd_pkg::CNT_W-1:0]        count_out_o
);
  import thd_pkg::*;

  localparam int unsigned HW = (HANDLE_BITS < DATA_W) ? HANDLE_BITS : DATA_W;
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = KEY_W + HW;

  function automatic logic [PW-1:0] pos_next(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] pos_prev(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
  endfunction

  // Entry memory: key above, handle below.
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_q;
  logic          we, re;
  logic [PW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  state_e        state_q, state_d;
  logic [PW-1:0] front_q, front_d, back_q, back_d, scan_pos_q, scan_pos_d;
  logic [CW-1:0] count_q, count_d, scan_idx_q, scan_idx_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [HW-1:0] res_handle_q, res_handle_d;
  status_e       res_status_q, res_status_d;
  logic          out_valid_q, out_valid_d;
  logic [HW-1:0] out_handle_q, out_handle_d;
  status_e       out_status_q, out_status_d;
  logic [CW-1:0] out_count_q, out_count_d;

  op_e           op;
  logic [HW-1:0] h_in;
  logic          is_empty, is_full, out_free, scan_hit, scan_end;

  assign op       = op_e'(op_i);
  assign h_in     = handle_in_i[HW-1:0];
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CW'(DEPTH));
  assign out_free = !out_valid_q || !out_stall_i;
  assign scan_hit = (rdata_q[HW +: KEY_W] == key_q);
  assign scan_end = (scan_idx_q == count_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op)
            OP_POP_FRONT, OP_POP_BACK: state_d = is_empty ? S_DONE : S_READ;
            OP_FIND:                   state_d = is_empty ? S_DONE : S_SCAN;
            default:                   state_d = S_DONE;
          endcase
        end
      end
      S_READ: state_d = S_DONE;
      S_SCAN: begin
        if (scan_hit || scan_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    front_d      = front_q;
    back_d       = back_q;
    count_d      = count_q;
    scan_pos_d   = scan_pos_q;
    scan_idx_d   = scan_idx_q;
    key_d        = key_q;
    res_handle_d = res_handle_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_handle_d = out_handle_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    we           = 1'b0;
    waddr        = back_q;
    wdata        = {key_in_i, h_in};
    re           = 1'b0;
    raddr        = front_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_handle_d = '0;
          res_status_d = ST_OK;
          case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (h_in == '0) begin
                res_status_d = ST_NULL;
              end else if (is_full) begin
                res_status_d = ST_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + 1'b1;
                if (op == OP_PUSH_FRONT) begin
                  waddr   = pos_prev(front_q);
                  front_d = pos_prev(front_q);
                end else begin
                  waddr  = back_q;
                  back_d = pos_next(back_q);
                end
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                re      = 1'b1;
                raddr   = front_q;
                front_d = pos_next(front_q);
                count_d = count_q - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                re      = 1'b1;
                raddr   = pos_prev(back_q);
                back_d  = pos_prev(back_q);
                count_d = count_q - 1'b1;
              end
            end
            OP_FIND: begin
              key_d        = key_in_i;
              res_status_d = ST_MISS;
              if (!is_empty) begin
                re         = 1'b1;
                raddr      = front_q;
                scan_pos_d = pos_next(front_q);
                scan_idx_d = CW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_handle_d = rdata_q[HW-1:0];
      end
      S_SCAN: begin
        if (scan_hit) begin
          res_handle_d = rdata_q[HW-1:0];
          res_status_d = ST_OK;
        end else if (!scan_end) begin
          re         = 1'b1;
          raddr      = scan_pos_q;
          scan_pos_d = pos_next(scan_pos_q);
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_handle_d = res_handle_q;
          out_status_d = res_status_q;
          out_count_d  = count_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      back_q      <= back_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_pos_q   <= scan_pos_d;
    scan_idx_q   <= scan_idx_d;
    key_q        <= key_d;
    res_handle_q <= res_handle_d;
    res_status_q <= res_status_d;
    out_handle_q <= out_handle_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign handle_out_o = DATA_W'(out_handle_q);
  assign status_o     = out_status_q;
  assign count_out_o  = CNT_W'(out_count_q);

endmodule

`default_nettype wire

FILE: rtl/thd_checker.sv
`default_nettype none

module thd_checker #(
  parameter int unsigned DEPTH = 16
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [thd_pkg::DATA_W-1:0]  handle_out_o,
  input wire logic [thd_pkg::ST_W-1:0]    status_o,
  input wire logic [thd_pkg::CNT_W-1:0]   count_out_o
);
  import thd_pkg::*;

  // A result held under stall keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(handle_out_o)
      && $stable(status_o) && $stable(count_out_o))
    else $error("result changed while stalled");

  // Every status other than ok carries a zero handle.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> handle_out_o == '0)
    else $error("nonzero handle with error status");

  // A refused push reports a full queue.
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> count_out_o == CNT_W'(DEPTH))
    else $error("full status with wrong count");

  // A pop on an empty queue leaves it empty.
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> count_out_o == '0)
    else $error("empty status with nonzero count");

  // Right after a request is taken the block holds off the next one.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

endmodule

bind task_handle_deque thd_checker #(.DEPTH(DEPTH)) u_thd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .handle_out_o(handle_out_o),
  .status_o    (status_o),
  .count_out_o (count_out_o)
);

`default_nettype wire

FILE: sim/task_handle_deque_checker.sv
`timescale 1ns / 1ps

module task_handle_deque_checker #(
  parameter int DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [thd_pkg::OP_W-1:0]    op_i,
  input  logic [thd_pkg::DATA_W-1:0]  handle_in_i,
  input  logic [thd_pkg::KEY_W-1:0]   key_in_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [thd_pkg::DATA_W-1:0]  handle_out_i,
  input  logic [thd_pkg::ST_W-1:0]    status_i,
  input  logic [thd_pkg::CNT_W-1:0]   count_out_i,
  output int                          fail_count_o,
  output int                          due_count_o,
  output int                          checked_count_o,
  output int                          found_count_o,
  output int                          full_count_o,
  output int                          empty_count_o,
  output int                          miss_count_o,
  output int                          null_count_o
);
  import thd_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] handle;
    status_e           status;
    logic [CNT_W-1:0]  count;
  } deque_reply_t;

  deque_reply_t replies_due[$];

  // Shadow copy of the deque contents, kept as a ring like the block's own.
  logic [DATA_W-1:0] slot_handle [DEPTH];
  logic [KEY_W-1:0]  slot_key [DEPTH];
  int                head_idx;
  int                tail_idx;
  int                fill;

  function automatic int next_slot(input int p);
    return (p == DEPTH - 1) ? 0 : p + 1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] task_handle_deque mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  task automatic apply_deque_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] handle,
                                input logic [KEY_W-1:0] key, output deque_reply_t reply);
    int idx;
    reply.handle = '0;
    reply.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        // A null handle is ignored before the full check, so it wins on a full deque.
        if (handle == '0) begin
          reply.status = ST_NULL;
        end else if (fill >= DEPTH) begin
          reply.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
          slot_handle[head_idx] = handle;
          slot_key[head_idx] = key;
          fill++;
        end else begin
          slot_handle[tail_idx] = handle;
          slot_key[tail_idx] = key;
          tail_idx = next_slot(tail_idx);
          fill++;
        end
      end
      OP_POP_FRONT: begin
        if (fill == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.handle = slot_handle[head_idx];
          head_idx = next_slot(head_idx);
          fill--;
        end
      end
      OP_POP_BACK: begin
        if (fill == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
          reply.handle = slot_handle[tail_idx];
          fill--;
        end
      end
      OP_FIND: begin
        // The scan covers every held entry, the one at the back included.
        reply.status = ST_MISS;
        idx = head_idx;
        for (int n = 0; n < fill; n++) begin
          if (reply.status == ST_MISS && slot_key[idx] == key) begin
            reply.handle = slot_handle[idx];
            reply.status = ST_OK;
          end
          idx = next_slot(idx);
        end
      end
      default: begin
      end
    endcase
    reply.count = CNT_W'(fill);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    deque_reply_t want;
    deque_reply_t made;
    if (!rst_ni) begin
      head_idx = 0;
      tail_idx = 0;
      fill = 0;
      replies_due.delete();
      due_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding (handle %h status %0d)",
                                    handle_out_i, status_i));
        end else begin
          want = replies_due.pop_front();
          checked_count_o++;
          if (handle_out_i !== want.handle)
            report_mismatch($sformatf("handle_out %h, expected %h", handle_out_i, want.handle));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_i, want.status));
          if (count_out_i !== want.count)
            report_mismatch($sformatf("count_out %0d, expected %0d", count_out_i, want.count));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_deque_op(op_i, handle_in_i, key_in_i, made);
        replies_due.push_back(made);
        if (op_i == OP_FIND && made.status == ST_OK) found_count_o++;
        case (made.status)
          ST_FULL:  full_count_o++;
          ST_EMPTY: empty_count_o++;
          ST_MISS:  miss_count_o++;
          ST_NULL:  null_count_o++;
          default: begin
          end
        endcase
      end
      due_count_o = replies_due.size();
    end
  end

endmodule

FILE: sim/task_handle_deque_tb.sv
`timescale 1ns / 1ps

module task_handle_deque_tb;
  import thd_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 400000;

  // Op codes the block treats as no operation.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic [OP_W-1:0]   op_i = '0;
  logic [DATA_W-1:0] handle_in_i = '0;
  logic [KEY_W-1:0]  key_in_i = '0;
  logic              out_stall_i = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [DATA_W-1:0] handle_out_o;
  logic [ST_W-1:0]   status_o;
  logic [CNT_W-1:0]  count_out_o;

  int fail_count;
  int due_count;
  int checked_count;
  int found_count;
  int full_count;
  int empty_count;
  int miss_count;
  int null_count;
  int cycle_count = 0;

  // No idling on either side while this is set.
  logic calm = 1'b0;
  logic [KEY_W-1:0] key_pool [6];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task_handle_deque #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (32)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .handle_in_i  (handle_in_i),
    .key_in_i     (key_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .handle_out_o (handle_out_o),
    .status_o     (status_o),
    .count_out_o  (count_out_o)
  );

  task_handle_deque_checker #(
    .DEPTH (DEPTH)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .op_i            (op_i),
    .handle_in_i     (handle_in_i),
    .key_in_i        (key_in_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .handle_out_i    (handle_out_o),
    .status_i        (status_o),
    .count_out_i     (count_out_o),
    .fail_count_o    (fail_count),
    .due_count_o     (due_count),
    .checked_count_o (checked_count),
    .found_count_o   (found_count),
    .full_count_o    (full_count),
    .empty_count_o   (empty_count),
    .miss_count_o    (miss_count),
    .null_count_o    (null_count)
  );

  always @(negedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 37);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("task_handle_deque regression: fail");
    $finish;
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] handle,
                              input logic [KEY_W-1:0] key);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    handle_in_i <= handle;
    key_in_i    <= key;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_deque_replies();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_count != 0) @(negedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 85) return key_pool[$urandom_range(5)];
    return $urandom();
  endfunction

  function automatic logic [DATA_W-1:0] pick_handle();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 7) return '1;
    if (r < 9) return 32'h1;
    return $urandom();
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int mode);
    int r;
    int push_lim;
    int pop_lim;
    r = $urandom_range(99);
    push_lim = (mode == MODE_GROW) ? 80 : (mode == MODE_SHRINK) ? 20 : 35;
    pop_lim  = (mode == MODE_GROW) ? 90 : (mode == MODE_SHRINK) ? 80 : 70;
    if (r < push_lim) return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < pop_lim) return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    if (r < 97) return OP_FIND;
    return OP_SPARE_LO + OP_W'($urandom_range(2));
  endfunction

  initial begin
    int mode;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty deque: pops report empty and a find misses.
    send_request(OP_POP_FRONT, '0, '0);
    send_request(OP_POP_BACK, '0, '0);
    send_request(OP_FIND, '0, '0);
    send_request(OP_PUSH_FRONT, '0, 32'h5);
    send_request(OP_PUSH_BACK, '0, '1);
    send_request(OP_PUSH_FRONT, '1, '0);
    send_request(OP_PUSH_BACK, 32'h1, '1);
    send_request(OP_PUSH_FRONT, 32'h8000_0000, 32'h1234);
    // The match at the back entry must be found too.
    send_request(OP_FIND, '0, '1);
    send_request(OP_FIND, '0, '0);
    send_request(OP_FIND, '0, 32'h1234);
    send_request(OP_FIND, '0, 32'h5555);
    send_request(OP_SPARE_LO, 32'hA5A5_A5A5, 32'h1234);
    send_request(OP_SPARE_LO + 3'd1, 32'h1, '0);
    send_request(OP_SPARE_HI, '1, '1);
    // A duplicate key further back must not shadow the first one from the front.
    send_request(OP_PUSH_BACK, 32'h7, '0);
    send_request(OP_FIND, '0, '0);
    send_request(OP_POP_FRONT, '0, '0);
    send_request(OP_POP_BACK, '0, '0);
    send_request(OP_POP_BACK, '0, '0);
    send_request(OP_POP_FRONT, '0, '0);
    send_request(OP_POP_BACK, '0, '0);
    drain_deque_replies();

    mode = MODE_GROW;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) mode = (i == 0) ? MODE_GROW : $urandom_range(2);
      calm = (i >= 700 && i < 950);
      if (i % 250 == 249) drain_deque_replies();
      send_request(pick_op(mode), pick_handle(), pick_key());
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (due_count != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);

    $display("Checked %0d replies: %0d finds hit, %0d misses, %0d empty pops.",
             checked_count, found_count, miss_count, empty_count);
    $display("Pushes refused on a full deque: %0d; null pushes ignored: %0d.",
             full_count, null_count);
    if (fail_count == 0) begin
      $display("task_handle_deque regression: pass");
    end else begin
      $display("task_handle_deque regression: fail");
    end
    $finish;
  end

endmodule
